### design/rvc_exp_pkg.sv
// ----------------------------------------------------------------------------
// rvc_exp_pkg
// Opcodes, field codes and instruction formatters for the RV32C expander.
// ----------------------------------------------------------------------------
package rvc_exp_pkg;

    // Compressed quadrants (bits 1:0)
    localparam logic [1:0] QUAD_0 = 2'b00;
    localparam logic [1:0] QUAD_1 = 2'b01;
    localparam logic [1:0] QUAD_2 = 2'b10;

    // Compressed funct3 (bits 15:13)
    localparam logic [2:0] CF3_0 = 3'd0;
    localparam logic [2:0] CF3_1 = 3'd1;
    localparam logic [2:0] CF3_2 = 3'd2;
    localparam logic [2:0] CF3_3 = 3'd3;
    localparam logic [2:0] CF3_4 = 3'd4;
    localparam logic [2:0] CF3_5 = 3'd5;
    localparam logic [2:0] CF3_6 = 3'd6;
    localparam logic [2:0] CF3_7 = 3'd7;

    // Quadrant 1, funct3 100 sub-op (bits 11:10)
    localparam logic [1:0] CB_SRLI = 2'd0;
    localparam logic [1:0] CB_SRAI = 2'd1;
    localparam logic [1:0] CB_ANDI = 2'd2;
    localparam logic [1:0] CB_ALU  = 2'd3;

    // Register ALU sub-op (bits 6:5)
    localparam logic [1:0] CA_SUB = 2'd0;
    localparam logic [1:0] CA_XOR = 2'd1;
    localparam logic [1:0] CA_OR  = 2'd2;
    localparam logic [1:0] CA_AND = 2'd3;

    // RV32I major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // RV32I funct3 / funct7
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Register numbers
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    localparam logic [11:0] IMM_SRA   = 12'h400;
    localparam logic [11:0] IMM_EBRK  = 12'h001;
    localparam logic [31:0] WORD_NONE = 32'h0000_0000;

    typedef logic [15:0] t_cinstr;
    typedef logic [31:0] t_instr;

    function automatic t_instr enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                     logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic t_instr enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                     logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic t_instr enc_r(logic [4:0] rd, logic [2:0] f3, logic [4:0] rs1,
                                     logic [4:0] rs2, logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic t_instr enc_b(logic [2:0] f3, logic [4:0] rs1, logic [12:0] imm);
        return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic t_instr enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

endpackage

### design/rv32c_instruction_expander.sv
// ----------------------------------------------------------------------------
// rv32c_instruction_expander
// Expands a 16-bit RV32C instruction into its 32-bit RV32I equivalent.
// ----------------------------------------------------------------------------
//  channel | valid        | ready         | payload
//  --------+--------------+---------------+-------------------------------------
//  in      | i_in_valid   | o_in_ready    | i_short_instruction
//  out     | o_out_valid  | i_out_ready   | o_expanded_instruction, o_illegal
//
//  One instruction per cycle while the output is not stalled; each input
//  passes through the input register, the decode and the result register,
//  and the result is presented from the result register.
//  A single combinational decode stage lies between the two registers.
//  i_rst_n is synchronous, active low, and empties both stages.
//  A stalled result holds the result register; the input stage keeps
//  accepting until it too is full, and ready follows as soon as a slot frees.
// ----------------------------------------------------------------------------
module rv32c_instruction_expander (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rvc_exp_pkg::t_cinstr i_short_instruction,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rvc_exp_pkg::t_instr  o_expanded_instruction,
    output logic                 o_illegal
);
    import rvc_exp_pkg::*;

    logic    r_s1_valid, n_s1_valid;
    t_cinstr r_s1_instr;
    logic    r_out_valid, n_out_valid;
    t_instr  r_out_word;
    logic    r_out_ill;

    logic    s2_adv;
    logic    s1_load;

    t_cinstr c;
    t_instr  word;
    logic [4:0]  rd, rs2, rdp, rs1p;
    logic [11:0] ci, clw, imm_4spn, imm_16sp, imm_lwsp, imm_swsp;
    logic [20:0] cj;
    logic [12:0] cb;

    // ---- handshake ----
    assign s2_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_adv;
    assign s1_load    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s2_adv) begin
            n_s1_valid = 1'b0;
        end
        if (s2_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_instr <= i_short_instruction;
        end
        if (s2_adv) begin
            r_out_word <= word;
            r_out_ill  <= ~|word;
        end
    end

    // ---- field extraction ----
    assign c        = r_s1_instr;
    assign rd       = c[11:7];
    assign rs2      = c[6:2];
    assign rdp      = {2'b01, c[4:2]};
    assign rs1p     = {2'b01, c[9:7]};
    assign ci       = {{7{c[12]}}, c[6:2]};
    assign clw      = {5'd0, c[5], c[12:10], c[6], 2'b00};
    assign imm_4spn = {2'b00, c[10:7], c[12:11], c[5], c[6], 2'b00};
    assign imm_16sp = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000};
    assign imm_lwsp = {4'd0, c[3:2], c[12], c[6:4], 2'b00};
    assign imm_swsp = {4'd0, c[8:7], c[12:9], 2'b00};
    assign cj       = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    assign cb       = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};

    // ---- expansion ----
    always_comb begin
        word = WORD_NONE;
        case (c[1:0])
            QUAD_0: begin
                case (c[15:13])
                    CF3_0: begin
                        if (imm_4spn != '0) begin
                            word = enc_i(OPC_OPIMM, rdp, F3_ADD, REG_SP, imm_4spn);
                        end
                    end
                    CF3_2:   word = enc_i(OPC_LOAD, rdp, F3_W, rs1p, clw);
                    CF3_6:   word = enc_s(F3_W, rs1p, rdp, clw);
                    default: word = WORD_NONE;
                endcase
            end
            QUAD_1: begin
                case (c[15:13])
                    CF3_0: word = enc_i(OPC_OPIMM, rd, F3_ADD, rd, ci);
                    CF3_1: word = enc_j(REG_RA, cj);
                    CF3_2: word = enc_i(OPC_OPIMM, rd, F3_ADD, REG_ZERO, ci);
                    CF3_3: begin
                        if (rd == REG_SP) begin
                            if (imm_16sp != '0) begin
                                word = enc_i(OPC_OPIMM, REG_SP, F3_ADD, REG_SP, imm_16sp);
                            end
                        end else if (ci != '0) begin
                            word = {{14{c[12]}}, c[12], c[6:2], rd, OPC_LUI};
                        end
                    end
                    CF3_4: begin
                        case (c[11:10])
                            CB_SRLI: begin
                                if (!c[12]) begin
                                    word = enc_i(OPC_OPIMM, rs1p, F3_SR, rs1p,
                                                 {7'd0, c[6:2]});
                                end
                            end
                            CB_SRAI: begin
                                if (!c[12]) begin
                                    word = enc_i(OPC_OPIMM, rs1p, F3_SR, rs1p,
                                                 IMM_SRA | {7'd0, c[6:2]});
                                end
                            end
                            CB_ANDI: word = enc_i(OPC_OPIMM, rs1p, F3_AND, rs1p, ci);
                            default: begin
                                // bit 12 set selects the RV64 word ops / reserved
                                if (!c[12]) begin
                                    case (c[6:5])
                                        CA_SUB:  word = enc_r(rs1p, F3_ADD, rs1p, rdp, F7_ALT);
                                        CA_XOR:  word = enc_r(rs1p, F3_XOR, rs1p, rdp, F7_BASE);
                                        CA_OR:   word = enc_r(rs1p, F3_OR, rs1p, rdp, F7_BASE);
                                        CA_AND:  word = enc_r(rs1p, F3_AND, rs1p, rdp, F7_BASE);
                                        default: word = WORD_NONE;
                                    endcase
                                end
                            end
                        endcase
                    end
                    CF3_5:   word = enc_j(REG_ZERO, cj);
                    CF3_6:   word = enc_b(F3_BEQ, rs1p, cb);
                    CF3_7:   word = enc_b(F3_BNE, rs1p, cb);
                    default: word = WORD_NONE;
                endcase
            end
            QUAD_2: begin
                case (c[15:13])
                    CF3_0: begin
                        if (!c[12]) begin
                            word = enc_i(OPC_OPIMM, rd, F3_SLL, rd, {7'd0, c[6:2]});
                        end
                    end
                    CF3_2: begin
                        if (rd != REG_ZERO) begin
                            word = enc_i(OPC_LOAD, rd, F3_W, REG_SP, imm_lwsp);
                        end
                    end
                    CF3_4: begin
                        if (c[12]) begin
                            if (rs2 != REG_ZERO) begin
                                word = enc_r(rd, F3_ADD, rd, rs2, F7_BASE);
                            end else if (rd == REG_ZERO) begin
                                word = enc_i(OPC_SYSTEM, REG_ZERO, F3_ADD, REG_ZERO, IMM_EBRK);
                            end else begin
                                word = enc_i(OPC_JALR, REG_RA, F3_ADD, rd, 12'd0);
                            end
                        end else if (rs2 != REG_ZERO) begin
                            word = enc_r(rd, F3_ADD, REG_ZERO, rs2, F7_BASE);
                        end else if (rd != REG_ZERO) begin
                            word = enc_i(OPC_JALR, REG_ZERO, F3_ADD, rd, 12'd0);
                        end
                    end
                    CF3_6:   word = enc_s(F3_W, REG_SP, rs2, imm_swsp);
                    default: word = WORD_NONE;
                endcase
            end
            default: word = WORD_NONE;
        endcase
    end

    assign o_out_valid            = r_out_valid;
    assign o_expanded_instruction = r_out_word;
    assign o_illegal              = r_out_ill;

`ifndef SYNTH
    // illegal results carry an all-zero word
    a_ill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_illegal |-> o_expanded_instruction == WORD_NONE)
        else $error("illegal result with nonzero word");

    // every legal expansion is a 32-bit encoding
    a_legal_32: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_illegal |-> o_expanded_instruction[1:0] == 2'b11)
        else $error("legal result is not a 32-bit encoding");

    // quadrant-3 input always comes out illegal
    a_q3_ill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv && r_s1_instr[1:0] == 2'b11 |=> o_out_valid && o_illegal)
        else $error("uncompressed input not flagged illegal");

    // a held input-stage item is neither lost nor altered
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_adv |=> r_s1_valid && $stable(r_s1_instr))
        else $error("input stage dropped or changed a held item");

    // a transfer in always lands in the input stage
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load |=> r_s1_valid)
        else $error("input transfer lost");
`endif

endmodule
